[src/tisp_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the temporal instruction stream prefetcher.
// No dependencies; used by the top level.
package tisp_pkg;

  localparam int LOG_DEPTH   = 1024;
  localparam int INDEX_SETS  = 1024;
  localparam int INDEX_WAYS  = 4;
  localparam int BLOCK_BYTES = 64;
  localparam int MAX_OUT     = 8;

  localparam int ADDR_W  = 64;
  localparam int BLK_SH  = $clog2(BLOCK_BYTES);
  localparam int BLK_W   = ADDR_W - BLK_SH;
  localparam int LOG_AW  = $clog2(LOG_DEPTH);
  localparam int SET_AW  = $clog2(INDEX_SETS);
  localparam int TAG_W   = BLK_W - SET_AW;
  localparam int WAY_W   = (INDEX_WAYS > 1) ? $clog2(INDEX_WAYS) : 1;
  localparam int RANK_W  = WAY_W;
  localparam int DEPTH_W = 4;
  localparam int DATA_W  = 32;

  // One way of an index set.
  typedef struct packed {
    logic              valid;
    logic [RANK_W-1:0] rank;
    logic [TAG_W-1:0]  tag;
    logic [LOG_AW-1:0] pos;
  } way_t;

  typedef way_t [INDEX_WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

endpackage

[src/tisp_ram.sv]
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// No dependencies.
module tisp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, or registered read; rdata holds between reads.
  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[addr] <= wdata;
    end else if (en) begin
      rdata <= mem[addr];
    end
  end

endmodule

[src/temporal_instruction_stream_prefetcher.sv]
`timescale 1ns / 1ps
// A fetch hit starts no work. A miss scans the index set, writes it back, appends itself
// to the log and may then issue prefetches, each one log RAM read and one result. The
// index set is scanned one way a cycle through a single tag comparator. Results cannot be
// stalled. After reset a clearing pass (one index set a cycle) runs with busy high;
// configuration writes are taken throughout.
// Depends on tisp_pkg and tisp_ram.
module temporal_instruction_stream_prefetcher
  import tisp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [ADDR_W-1:0]   in_fetch_address,
  input  logic                in_was_hit,
  output logic                out_valid,
  output logic [ADDR_W-1:0]   out_prefetch_block_address,
  output logic                out_last_prefetch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  typedef enum logic [2:0] {
    ST_CLR, ST_IDLE, ST_CMP, ST_UPD, ST_CHK, ST_RQ, ST_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  logic [SET_AW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [BLK_W-1:0]   blk_r, blk_nxt;
  logic [WAY_W-1:0]   way_r, way_nxt;
  logic               found_r, found_nxt;
  logic [WAY_W-1:0]   hit_way_r, hit_way_nxt;
  logic               inv_found_r, inv_found_nxt;
  logic [WAY_W-1:0]   inv_way_r, inv_way_nxt;
  logic [RANK_W-1:0]  oldest_r, oldest_nxt;
  logic [WAY_W-1:0]   old_way_r, old_way_nxt;
  logic [LOG_AW-1:0]  old_r, old_nxt;
  logic [LOG_AW-1:0]  tail_r, tail_nxt;
  logic [LOG_AW-1:0]  pos_r, pos_nxt;
  logic [DEPTH_W-1:0] n_r, n_nxt;
  logic [DEPTH_W-1:0] cnt_r, cnt_nxt;
  logic [DEPTH_W-1:0] depth_r;
  logic               out_valid_r, out_valid_nxt;
  logic [BLK_W-1:0]   out_blk_r, out_blk_nxt;
  logic               out_last_r, out_last_nxt;

  logic               idx_en, idx_we;
  logic [SET_AW-1:0]  idx_addr;
  row_t               idx_wdata, idx_rdata;
  logic               log_en, log_we;
  logic [LOG_AW-1:0]  log_addr;
  logic [BLK_W-1:0]   log_wdata, log_rdata;

  logic               accept;
  way_t               cur_way;
  logic [WAY_W-1:0]   victim;
  logic [RANK_W:0]    old_rank;
  row_t               new_row;
  logic [DEPTH_W-1:0] dep_clamp;
  logic [LOG_AW-1:0]  avail;
  logic [DEPTH_W-1:0] n_calc;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Configuration port: a single depth register, always ready.
  assign pready = 1'b1;
  assign prdata = DATA_W'(depth_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= DEPTH_W'(3);
    end else if (psel && penable && pwrite && pready) begin
      depth_r <= pwdata[DEPTH_W-1:0];
    end
  end

  tisp_ram #(.WIDTH(ROW_W), .DEPTH(INDEX_SETS)) u_index (
    .clk   (clk),
    .en    (idx_en),
    .we    (idx_we),
    .addr  (idx_addr),
    .wdata (idx_wdata),
    .rdata (idx_rdata)
  );

  tisp_ram #(.WIDTH(BLK_W), .DEPTH(LOG_DEPTH)) u_log (
    .clk   (clk),
    .en    (log_en),
    .we    (log_we),
    .addr  (log_addr),
    .wdata (log_wdata),
    .rdata (log_rdata)
  );

  // Way under the shared comparator this cycle.
  assign cur_way = idx_rdata[way_r];

  // Replacement choice and rank update of the set being written back.
  always_comb begin
    if (found_r) begin
      victim   = hit_way_r;
      old_rank = {1'b0, idx_rdata[hit_way_r].rank};
    end else begin
      victim   = inv_found_r ? inv_way_r : old_way_r;
      old_rank = (RANK_W + 1)'(INDEX_WAYS);
    end
    new_row = idx_rdata;
    for (int k = 0; k < INDEX_WAYS; k++) begin
      if (WAY_W'(k) != victim && idx_rdata[k].valid &&
          {1'b0, idx_rdata[k].rank} < old_rank &&
          {1'b0, idx_rdata[k].rank} < (RANK_W + 1)'(INDEX_WAYS - 1)) begin
        new_row[k].rank = idx_rdata[k].rank + RANK_W'(1);
      end
    end
    new_row[victim].rank  = '0;
    new_row[victim].valid = 1'b1;
    new_row[victim].tag   = blk_r[BLK_W-1:SET_AW];
    new_row[victim].pos   = tail_r;
  end

  // Prefetches: depth capped at MAX_OUT, limited by the log entries after the old one.
  always_comb begin
    dep_clamp = (depth_r > DEPTH_W'(MAX_OUT)) ? DEPTH_W'(MAX_OUT) : depth_r;
    avail     = tail_r - old_r - LOG_AW'(1);
    n_calc    = (LOG_AW'(dep_clamp) < avail) ? dep_clamp : avail[DEPTH_W-1:0];
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    blk_nxt       = blk_r;
    way_nxt       = way_r;
    found_nxt     = found_r;
    hit_way_nxt   = hit_way_r;
    inv_found_nxt = inv_found_r;
    inv_way_nxt   = inv_way_r;
    oldest_nxt    = oldest_r;
    old_way_nxt   = old_way_r;
    old_nxt       = old_r;
    tail_nxt      = tail_r;
    pos_nxt       = pos_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_blk_nxt   = out_blk_r;
    out_last_nxt  = out_last_r;
    idx_en        = 1'b0;
    idx_we        = 1'b0;
    idx_addr      = blk_r[SET_AW-1:0];
    idx_wdata     = new_row;
    log_en        = 1'b0;
    log_we        = 1'b0;
    log_addr      = pos_r;
    log_wdata     = blk_r;
    case (state_r)
      ST_CLR: begin
        idx_en      = 1'b1;
        idx_we      = 1'b1;
        idx_addr    = clr_cnt_r;
        idx_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + SET_AW'(1);
        if (clr_cnt_r == SET_AW'(INDEX_SETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && !in_was_hit) begin
          blk_nxt       = in_fetch_address[ADDR_W-1:BLK_SH];
          idx_en        = 1'b1;
          idx_addr      = in_fetch_address[BLK_SH +: SET_AW];
          way_nxt       = '0;
          found_nxt     = 1'b0;
          inv_found_nxt = 1'b0;
          oldest_nxt    = '0;
          old_way_nxt   = '0;
          state_nxt     = ST_CMP;
        end
      end
      ST_CMP: begin
        // One way a cycle: tag match, first free way, oldest way.
        if (!found_r && cur_way.valid && cur_way.tag == blk_r[BLK_W-1:SET_AW]) begin
          found_nxt   = 1'b1;
          hit_way_nxt = way_r;
        end
        if (!inv_found_r && !cur_way.valid) begin
          inv_found_nxt = 1'b1;
          inv_way_nxt   = way_r;
        end
        if (cur_way.rank > oldest_r) begin
          oldest_nxt  = cur_way.rank;
          old_way_nxt = way_r;
        end
        way_nxt = way_r + WAY_W'(1);
        if (way_r == WAY_W'(INDEX_WAYS - 1)) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        // Write back the set and read the log entry of the previous miss.
        idx_en    = 1'b1;
        idx_we    = 1'b1;
        old_nxt   = idx_rdata[hit_way_r].pos;
        log_en    = 1'b1;
        log_addr  = idx_rdata[hit_way_r].pos;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        // Append this miss and decide whether the stream is still live.
        log_en    = 1'b1;
        log_we    = 1'b1;
        log_addr  = tail_r;
        tail_nxt  = tail_r + LOG_AW'(1);
        pos_nxt   = old_r;
        cnt_nxt   = '0;
        n_nxt     = n_calc;
        if (found_r && log_rdata == blk_r && n_calc != '0) begin
          state_nxt = ST_RQ;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RQ: begin
        log_en    = 1'b1;
        log_addr  = pos_r + LOG_AW'(1);
        pos_nxt   = pos_r + LOG_AW'(1);
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_nxt = 1'b1;
        out_blk_nxt   = log_rdata;
        out_last_nxt  = (cnt_r + DEPTH_W'(1) == n_r);
        cnt_nxt       = cnt_r + DEPTH_W'(1);
        state_nxt     = (cnt_r + DEPTH_W'(1) == n_r) ? ST_IDLE : ST_RQ;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
    blk_r       <= blk_nxt;
    way_r       <= way_nxt;
    found_r     <= found_nxt;
    hit_way_r   <= hit_way_nxt;
    inv_found_r <= inv_found_nxt;
    inv_way_r   <= inv_way_nxt;
    oldest_r    <= oldest_nxt;
    old_way_r   <= old_way_nxt;
    old_r       <= old_nxt;
    pos_r       <= pos_nxt;
    n_r         <= n_nxt;
    cnt_r       <= cnt_nxt;
    out_blk_r   <= out_blk_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid                  = out_valid_r;
  assign out_prefetch_block_address = {out_blk_r, BLK_SH'(0)};
  assign out_last_prefetch          = out_last_r;

`ifndef SYNTHESIS
  // No result transfer during the clearing pass.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> !out_valid_r)
    else $error("result during index clearing");

  // A missing fetch makes the block busy on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_was_hit) |=> busy)
    else $error("miss accepted without going busy");

  // The issue count never passes the computed number of prefetches.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RQ || state_r == ST_EMIT) |-> (cnt_r < n_r))
    else $error("prefetch count overrun");

  // The final prefetch is followed by no further result.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |=> !out_valid_r)
    else $error("result after final prefetch");
`endif

endmodule
